// File: rtl/page_frame_allocator_directory_core_assert.svh
// assertion macros for the page frame allocator directory core
// PFAD_ASSERT_IMP: consequent checked in the same cycle as the antecedent
// PFAD_ASSERT_NXT: consequent checked in the cycle after the antecedent
`ifndef PAGE_FRAME_ALLOCATOR_DIRECTORY_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_DIRECTORY_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PFAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfad assertion failed");
`define PFAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfad assertion failed");
`else
`define PFAD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFAD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/pfad_pkg.sv
`default_nettype none

package pfad_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int PAGE_W    = 10;
    localparam int FLAGS_W   = 4;
    localparam int ENTRY_W   = PAGE_W + FLAGS_W;
    localparam int AMOUNT_W  = 11;
    localparam int DIR_DEPTH = 1024;

    // bitmap word layout
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_MAP   = 2'd3;

    // directory entry flags
    localparam int                 FLAG_PRESENT_BIT = 0;
    localparam logic [FLAGS_W-1:0] FLAGS_KERNEL     = 4'b1011;
    localparam logic [FLAGS_W-1:0] FLAGS_USER       = 4'b1111;
    localparam logic [PAGE_W-1:0]  KERNEL_HIGH_PAGE = 10'h300;
    localparam logic [ENTRY_W-1:0] KERNEL_ENTRY     = {{PAGE_W{1'b0}}, FLAGS_KERNEL};

    // controller to datapath commands
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic dir_rd;
        logic bmp_rd;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/page_frame_allocator_directory_core.sv
// channel   direction  handshake           payload
// request   in         i_valid / o_stall   operation, virtual_page, physical_frame,
//                                          entry_flags, amount
// result    out        o_valid / i_stall   success, frame_number, tlb_invalidate,
//                                          invalidate_page
//
// a request runs, accept to next accept, through the accepting cycle,
// directory read, bitmap word read, execute and write back
// its result enters the output register at write back
// the bitmap word read depends on the directory memory read, except for alloc
// after reset the directory is rewritten to its boot image, all 1024 entries, with o_stall high
// a held result blocks only the write back of the following request
`default_nettype none
`include "page_frame_allocator_directory_core_assert.svh"

module page_frame_allocator_directory_core
    import pfad_pkg::*;
#(
    parameter int FRAME_COUNT = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [PAGE_W-1:0]   i_virtual_page,
    input  wire logic [PAGE_W-1:0]   i_physical_frame,
    input  wire logic [FLAGS_W-1:0]  i_entry_flags,
    input  wire logic [AMOUNT_W-1:0] i_amount,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_success,
    output logic [PAGE_W-1:0]        o_frame_number,
    output logic                     o_tlb_invalidate,
    output logic [PAGE_W-1:0]        o_invalidate_page
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    pfad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // directory, bitmap and result register
    pfad_dp #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_operation       (i_operation),
        .i_virtual_page    (i_virtual_page),
        .i_physical_frame  (i_physical_frame),
        .i_entry_flags     (i_entry_flags),
        .i_amount          (i_amount),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_success         (o_success),
        .o_frame_number    (o_frame_number),
        .o_tlb_invalidate  (o_tlb_invalidate),
        .o_invalidate_page (o_invalidate_page)
    );

    // checks
    `PFAD_ASSERT_NXT(a_accept_blocks, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `PFAD_ASSERT_NXT(a_commit_shows, i_clk, i_rst_n, w_cmd.commit, o_valid)
    `PFAD_ASSERT_IMP(a_commit_room, i_clk, i_rst_n, w_cmd.commit, !o_valid || !i_stall)
    `PFAD_ASSERT_IMP(a_inval_ok, i_clk, i_rst_n, o_valid && o_tlb_invalidate, o_success)

endmodule

`default_nettype wire

// File: rtl/pfad_ctrl.sv
`default_nettype none

module pfad_ctrl
    import pfad_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIR   = 3'd2;
    localparam logic [2:0] S_BMP   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                o_cmd.dir_rd = 1'b1;
                n_state      = S_BMP;
            end
            S_BMP: begin
                o_cmd.bmp_rd = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/pfad_dp.sv
`default_nettype none

module pfad_dp
    import pfad_pkg::*;
#(
    parameter int FRAME_COUNT = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [PAGE_W-1:0]   i_virtual_page,
    input  wire logic [PAGE_W-1:0]   i_physical_frame,
    input  wire logic [FLAGS_W-1:0]  i_entry_flags,
    input  wire logic [AMOUNT_W-1:0] i_amount,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_success,
    output logic [PAGE_W-1:0]        o_frame_number,
    output logic                     o_tlb_invalidate,
    output logic [PAGE_W-1:0]        o_invalidate_page
);

    localparam int WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int HI_W  = AMOUNT_W - BIT_W;
    localparam logic [AMOUNT_W-1:0] FRAME_LIMIT = AMOUNT_W'(FRAME_COUNT);
    localparam logic [CNT_W-1:0]    CNT_RESET   = CNT_W'(FRAME_COUNT - 1);

    // request registers
    logic [OP_W-1:0]     r_op;
    logic [PAGE_W-1:0]   r_vpage;
    logic [PAGE_W-1:0]   r_pframe;
    logic [FLAGS_W-1:0]  r_flags;
    logic [AMOUNT_W-1:0] r_amount;

    // directory memory and clearing pass
    logic [ENTRY_W-1:0] r_dir_mem [DIR_DEPTH];
    logic [ENTRY_W-1:0] r_dir_rd;
    logic [PAGE_W-1:0]  r_clr_idx;
    logic               dir_we;
    logic [PAGE_W-1:0]  dir_wa;
    logic [ENTRY_W-1:0] dir_wd;
    logic [ENTRY_W-1:0] clr_entry;

    // frame bitmap, one word per row
    logic [WORD_BITS-1:0] r_bmp_mem [WORDS];
    logic [WORDS-1:0]     r_word_vld;
    logic [WORDS-1:0]     r_full;
    logic [CNT_W-1:0]     r_free_cnt;
    logic [WORD_BITS-1:0] r_bmp_rd;
    logic [WW-1:0]        r_bmp_idx;
    logic                 r_bmp_vld_rd;
    logic                 r_any_free;

    // output register
    logic                r_out_vld;
    logic                r_success;
    logic [PAGE_W-1:0]   r_frame;
    logic                r_inval;
    logic [PAGE_W-1:0]   r_inval_page;

    // combinational datapath
    logic [WW-1:0]        free_word_idx;
    logic                 any_free;
    logic [WW-1:0]        rd_idx;
    logic [PAGE_W-1:0]    entry_frame;
    logic                 entry_present;
    logic                 entry_in_range;
    logic [BIT_W-1:0]     free_bit;
    logic [WORD_BITS-1:0] eff_word;
    logic [WORD_BITS-1:0] pad;
    logic [WORD_BITS-1:0] search_word;
    logic [BIT_W-1:0]     low_bit;
    logic [PAGE_W-1:0]    alloc_frame;
    logic                 was_used;
    logic                 vpage_nz;
    logic                 ok;
    logic [PAGE_W-1:0]    res_frame;
    logic                 inval;
    logic                 dir_we_op;
    logic [ENTRY_W-1:0]   dir_wd_op;
    logic                 bmp_we_op;
    logic [WORD_BITS-1:0] bmp_new;
    logic                 full_new;
    logic [CNT_W-1:0]     cnt_new;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_vpage  <= i_virtual_page;
            r_pframe <= i_physical_frame;
            r_flags  <= i_entry_flags;
            r_amount <= i_amount;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_idx <= r_clr_idx + PAGE_W'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_idx == {PAGE_W{1'b1}});

    // directory write port
    always_comb begin
        clr_entry = '0;
        if (r_clr_idx == '0 || r_clr_idx == KERNEL_HIGH_PAGE) begin
            clr_entry = KERNEL_ENTRY;
        end
        dir_we = i_cmd.clr_wr | (i_cmd.commit & dir_we_op);
        dir_wa = i_cmd.clr_wr ? r_clr_idx : r_vpage;
        dir_wd = i_cmd.clr_wr ? clr_entry : dir_wd_op;
    end

    // directory memory
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_wa] <= dir_wd;
        end
        if (i_cmd.dir_rd) begin
            r_dir_rd <= r_dir_mem[r_vpage];
        end
    end

    // stored entry fields
    assign entry_frame    = r_dir_rd[ENTRY_W-1:FLAGS_W];
    assign entry_present  = r_dir_rd[FLAG_PRESENT_BIT];
    assign entry_in_range = ({1'b0, entry_frame} < FRAME_LIMIT);
    assign free_bit       = entry_frame[BIT_W-1:0];

    // lowest bitmap word that still has a free frame
    always_comb begin
        free_word_idx = '0;
        any_free      = 1'b0;
        for (int k = WORDS - 1; k >= 0; k--) begin
            if (!r_full[k]) begin
                free_word_idx = WW'(k);
                any_free      = 1'b1;
            end
        end
    end

    assign rd_idx = (r_op == OP_ALLOC) ? free_word_idx : entry_frame[BIT_W +: WW];

    // bitmap read
    always_ff @(posedge i_clk) begin
        if (i_cmd.bmp_rd) begin
            r_bmp_rd     <= r_bmp_mem[rd_idx];
            r_bmp_idx    <= rd_idx;
            r_bmp_vld_rd <= r_word_vld[rd_idx];
            r_any_free   <= any_free;
        end
    end

    // word as seen after reset, padding past the last frame
    always_comb begin
        if (r_bmp_vld_rd) begin
            eff_word = r_bmp_rd;
        end else begin
            eff_word = (r_bmp_idx == '0) ? WORD_BITS'(1) : '0;
        end
        for (int b = 0; b < WORD_BITS; b++) begin
            pad[b] = ({HI_W'(r_bmp_idx), BIT_W'(b)} >= FRAME_LIMIT);
        end
        search_word = eff_word | pad;
    end

    // lowest free bit in the word
    always_comb begin
        low_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!search_word[b]) begin
                low_bit = BIT_W'(b);
            end
        end
        alloc_frame = PAGE_W'({HI_W'(r_bmp_idx), low_bit});
    end

    assign was_used = eff_word[free_bit];
    assign vpage_nz = |r_vpage;

    // operation decode
    always_comb begin
        ok        = 1'b0;
        res_frame = '0;
        dir_we_op = 1'b0;
        dir_wd_op = '0;
        bmp_we_op = 1'b0;
        bmp_new   = eff_word;
        full_new  = 1'b0;
        cnt_new   = r_free_cnt;
        unique case (r_op)
            OP_CHECK: begin
                ok = (AMOUNT_W'(r_free_cnt) >= r_amount);
            end
            OP_ALLOC: begin
                if (vpage_nz && r_any_free) begin
                    ok        = 1'b1;
                    res_frame = alloc_frame;
                    dir_we_op = 1'b1;
                    dir_wd_op = {alloc_frame, FLAGS_USER};
                    bmp_we_op = 1'b1;
                    bmp_new   = eff_word | (WORD_BITS'(1) << low_bit);
                    full_new  = &(bmp_new | pad);
                    cnt_new   = r_free_cnt - CNT_W'(1);
                end
            end
            OP_FREE: begin
                if (vpage_nz && entry_present) begin
                    ok        = 1'b1;
                    res_frame = entry_frame;
                    dir_we_op = 1'b1;
                    dir_wd_op = '0;
                    if (entry_in_range) begin
                        bmp_we_op = 1'b1;
                        bmp_new   = eff_word & ~(WORD_BITS'(1) << free_bit);
                        full_new  = 1'b0;
                        cnt_new   = r_free_cnt + CNT_W'(was_used);
                    end
                end
            end
            OP_MAP: begin
                ok        = 1'b1;
                res_frame = r_pframe;
                dir_we_op = 1'b1;
                dir_wd_op = {r_pframe, r_flags};
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        inval = ok & (r_op != OP_CHECK);
    end

    // bitmap write
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && bmp_we_op) begin
            r_bmp_mem[r_bmp_idx] <= bmp_new;
        end
    end

    // bitmap bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_full     <= '0;
            r_free_cnt <= CNT_RESET;
        end else if (i_cmd.commit && bmp_we_op) begin
            r_word_vld[r_bmp_idx] <= 1'b1;
            r_full[r_bmp_idx]     <= full_new;
            r_free_cnt            <= cnt_new;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_success    <= ok;
            r_frame      <= res_frame;
            r_inval      <= inval;
            r_inval_page <= inval ? r_vpage : '0;
        end
    end

    assign o_sts.out_free   = !r_out_vld || !i_stall;
    assign o_valid          = r_out_vld;
    assign o_success        = r_success;
    assign o_frame_number   = r_frame;
    assign o_tlb_invalidate = r_inval;
    assign o_invalidate_page = r_inval_page;

endmodule

`default_nettype wire
